// ===== rtl/psw_pkg.sv =====
// shared types, constants and helpers of the pulse stamp word packer
`timescale 1ns / 1ps

package psw_pkg;

  localparam int WORD_W      = 16;
  localparam int CODE_W      = 31;
  localparam int DOM_BITS    = 13;
  localparam int OM_LOW_BITS = 6;
  localparam int OVF_W       = 15;
  localparam int NUM_SLOTS   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // word slots of one stamp, in emission order
  localparam int SLOT_STAMP = 0;
  localparam int SLOT_TOVF  = 1;
  localparam int SLOT_QOVF  = 2;
  localparam int SLOT_HDR   = 3;

  localparam logic STREAM_STAMP  = 1'b0;
  localparam logic STREAM_HEADER = 1'b1;

  typedef struct packed {
    logic [6:0]        string_number;
    logic [6:0]        om_number;
    logic              hlc;
    logic              last_stamp;
    logic [CODE_W-1:0] time_code;
    logic [CODE_W-1:0] charge_code;
  } in_item_t;

  typedef struct packed {
    logic              stream_select;
    logic [WORD_W-1:0] word;
    logic              last_word;
  } out_item_t;

  // one classified stamp: every word it may produce and which ones it does
  typedef struct packed {
    logic [NUM_SLOTS-1:0]             slot_vld;
    logic [NUM_SLOTS-1:0][WORD_W-1:0] words;
  } desc_t;

  function automatic logic [OVF_W-1:0] sat_excess(input logic [CODE_W-1:0] code,
                                                  input logic [CODE_W-1:0] maxv);
    logic [CODE_W-1:0] diff;
    diff = code - maxv;
    if (diff > CODE_W'(OVF_MAX)) begin
      return OVF_MAX;
    end
    return diff[OVF_W-1:0];
  endfunction

endpackage

// ===== rtl/psw_front.sv =====
// front end: accepts stamps, tracks readout start and builds all words of a stamp
`timescale 1ns / 1ps

module psw_front #(
  parameter int TIME_BITS   = 8,
  parameter int CHARGE_BITS = 6,
  parameter int SLOP_BITS   = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  psw_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output psw_pkg::desc_t    q_desc
);
  import psw_pkg::*;

  localparam int TMAX_W = TIME_BITS + SLOP_BITS;
  localparam logic [CODE_W-1:0] TMAX   = CODE_W'((1 << TMAX_W) - 1);
  localparam logic [CODE_W-1:0] TSMALL = CODE_W'((1 << TIME_BITS) - 1);
  localparam logic [CODE_W-1:0] QMAX   = CODE_W'((1 << CHARGE_BITS) - 1);

  logic                   expect_first_r;
  logic                   expect_first_nxt;
  logic                   tsat;
  logic                   tsat_eff;
  logic                   tlate_sat;
  logic                   qsat;
  logic [TMAX_W-1:0]      t_first;
  logic [TIME_BITS-1:0]   t_low;
  logic [CHARGE_BITS-1:0] q_val;
  logic [SLOP_BITS-1:0]   slop;
  logic [OM_LOW_BITS-1:0] om_m1;
  logic [DOM_BITS-1:0]    dom;
  logic [WORD_W-1:0]      stamp_body;
  logic [WORD_W-1:0]      slop_shift;
  logic                   stop;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign stop    = in_item.last_stamp;

  always_comb begin
    tsat      = in_item.time_code >= TMAX;
    tsat_eff  = expect_first_r && tsat;
    tlate_sat = in_item.time_code > TSMALL;
    qsat      = in_item.charge_code >= QMAX;
    t_first   = tsat ? TMAX[TMAX_W-1:0] : in_item.time_code[TMAX_W-1:0];
    if (expect_first_r) begin
      t_low = t_first[TIME_BITS-1:0];
    end else begin
      t_low = tlate_sat ? TSMALL[TIME_BITS-1:0] : in_item.time_code[TIME_BITS-1:0];
    end
    q_val = qsat ? QMAX[CHARGE_BITS-1:0] : in_item.charge_code[CHARGE_BITS-1:0];
    slop  = t_first[TMAX_W-1 -: SLOP_BITS];
    om_m1 = in_item.om_number[OM_LOW_BITS-1:0] - OM_LOW_BITS'(1);
    dom   = {in_item.string_number, om_m1};

    // fields ored at their spots, anything above bit 15 falls off
    stamp_body = WORD_W'(t_low) | (WORD_W'(q_val) << TIME_BITS)
               | (WORD_W'(in_item.hlc) << (TIME_BITS + CHARGE_BITS));
    slop_shift = WORD_W'(slop) << DOM_BITS;

    q_desc.slot_vld = '0;
    q_desc.slot_vld[SLOT_STAMP] = 1'b1;
    q_desc.slot_vld[SLOT_TOVF]  = tsat_eff;
    q_desc.slot_vld[SLOT_QOVF]  = qsat;
    q_desc.slot_vld[SLOT_HDR]   = expect_first_r;

    // stop bit rides on the last stamp-stream word
    q_desc.words[SLOT_STAMP] = stamp_body;
    q_desc.words[SLOT_STAMP][WORD_W-1] = stamp_body[WORD_W-1] | (stop && !tsat_eff && !qsat);
    q_desc.words[SLOT_TOVF] = {stop && !qsat, sat_excess(in_item.time_code, TMAX)};
    q_desc.words[SLOT_QOVF] = {stop, sat_excess(in_item.charge_code, QMAX)};
    q_desc.words[SLOT_HDR]  = WORD_W'(dom) | slop_shift;
  end

  assign expect_first_nxt = q_push ? in_item.last_stamp : expect_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_first_r <= 1'b1;
    end else begin
      expect_first_r <= expect_first_nxt;
    end
  end

endmodule

// ===== rtl/psw_queue.sv =====
// two-entry queue of classified stamps between front and back
`timescale 1ns / 1ps

module psw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psw_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output psw_pkg::desc_t head_desc,
  output logic           empty
);
  import psw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty     = cnt_r == '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/psw_back.sv =====
// back end: walks the valid word slots of each stamp, one word per cycle while the output register is free
`timescale 1ns / 1ps

module psw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  psw_pkg::desc_t      q_desc,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output psw_pkg::out_item_t  out_item
);
  import psw_pkg::*;

  logic [NUM_SLOTS-1:0][WORD_W-1:0] cur_words_r;
  logic [NUM_SLOTS-1:0][WORD_W-1:0] cur_words_nxt;
  logic [NUM_SLOTS-1:0]             rem_r;
  logic [NUM_SLOTS-1:0]             rem_nxt;
  logic                             out_vld_r;
  logic                             out_vld_nxt;
  out_item_t                        out_item_r;
  out_item_t                        out_item_nxt;
  logic                             active;
  logic                             out_free;
  logic                             emit;
  logic [NUM_SLOTS-1:0]             src_mask;
  logic [NUM_SLOTS-1:0][WORD_W-1:0] src_words;
  logic [NUM_SLOTS-1:0]             pick;
  logic [NUM_SLOTS-1:0]             left;
  logic [WORD_W-1:0]                pick_word;

  assign active    = rem_r != '0;
  assign out_free  = !out_vld_r || out_pop;
  assign out_empty = !out_vld_r;
  assign out_item  = out_item_r;

  always_comb begin
    src_mask  = active ? rem_r : (q_empty ? '0 : q_desc.slot_vld);
    src_words = active ? cur_words_r : q_desc.words;
    pick      = src_mask & (~src_mask + 1'b1);
    left      = src_mask & ~pick;
    emit      = out_free && (src_mask != '0);
    q_pop     = emit && !active;

    pick_word = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) begin
        pick_word = pick_word | src_words[i];
      end
    end

    cur_words_nxt = q_pop ? q_desc.words : cur_words_r;
    rem_nxt       = emit ? left : rem_r;

    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    if (emit) begin
      out_vld_nxt                = 1'b1;
      out_item_nxt.stream_select = pick[SLOT_HDR] ? STREAM_HEADER : STREAM_STAMP;
      out_item_nxt.word          = pick_word;
      out_item_nxt.last_word     = left == '0;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_words_r <= cur_words_nxt;
    out_item_r  <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// ===== rtl/pulse_stamp_word_packer.sv =====
// top level of the pulse stamp word packer: front, stamp queue and word sequencer
`timescale 1ns / 1ps
// a stamp passes the stamp queue and then the output register before its first word is on the out_ ports
// one result word per cycle while the receiver keeps popping; a stamp yields one to four
//   words (stamp, time overflow, charge overflow, header)
// a two-entry stamp queue lets the input keep taking stamps while words drain
// reset (rst_n low, synchronous): queue and output emptied, next stamp opens a readout

module pulse_stamp_word_packer #(
  parameter int TIME_BITS   = 8,
  parameter int CHARGE_BITS = 6,
  parameter int SLOP_BITS   = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  // stamp input, transfer on push && !full
  input  logic               in_push,
  input  psw_pkg::in_item_t  in_item,
  output logic               in_full,
  // word output, transfer on pop && !empty
  input  logic               out_pop,
  output logic               out_empty,
  output psw_pkg::out_item_t out_item
);
  import psw_pkg::*;

  // front to queue
  logic  fq_push;
  desc_t fq_desc;
  logic  q_full;
  // queue to back
  desc_t q_head;
  logic  q_empty;
  logic  q_pop;

  // front: registered readout tracking, combinational saturation and word building
  psw_front #(
    .TIME_BITS   (TIME_BITS),
    .CHARGE_BITS (CHARGE_BITS),
    .SLOP_BITS   (SLOP_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (fq_push),
    .q_desc  (fq_desc)
  );

  // short decoupling queue, holds whole classified stamps
  psw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_desc (fq_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head_desc (q_head),
    .empty     (q_empty)
  );

  // back: emits the valid words of the head stamp into the output register
  psw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_desc    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

// ===== bench/tb_pulse_stamp_word_packer.sv =====
// self-checking testbench of the pulse stamp word packer: directed table, then random readouts
`timescale 1ns / 1ps

module tb_pulse_stamp_word_packer;
  import psw_pkg::*;

  localparam int T_BITS = 8;
  localparam int Q_BITS = 6;
  localparam int S_BITS = 3;
  localparam int STALL_LIMIT = 3000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off that fills the block
  localparam int ITEMS_PER_PHASE = 47;

  // one row of the directed table; typed words are used where n_typed is nonzero
  typedef struct {
    in_item_t  item;
    int        n_typed;
    out_item_t typed [4];
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_item;
  logic      in_full;
  logic      out_pop;
  logic      out_empty;
  out_item_t out_item;

  // words still to come, oldest first
  out_item_t pending_words[$];
  out_item_t want_word;
  stim_row_t dir_rows[$];

  // predictor state: the next stamp opens a readout
  logic readout_start;

  int   err_count;
  int   stamps_sent;
  int   words_checked;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_count;
  logic hold_req;
  logic hold_done;

  pulse_stamp_word_packer #(
    .TIME_BITS  (T_BITS),
    .CHARGE_BITS(Q_BITS),
    .SLOP_BITS  (S_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  // excess over a saturated code, itself clamped to 15 bits
  function automatic logic [15:0] clamp_excess(input logic [CODE_W-1:0] code,
                                               input logic [CODE_W-1:0] ceil);
    logic [CODE_W-1:0] diff;
    diff = code - ceil;
    return (diff > CODE_W'(32'h7FFF)) ? 16'h7FFF : 16'(diff[14:0]);
  endfunction

  // words one stamp yields, in emission order; returns how many
  function automatic int pack_stamp(input in_item_t s, input logic first,
                                    output out_item_t w [4]);
    logic [CODE_W-1:0] q_ceil;
    logic [CODE_W-1:0] t_small;
    logic [CODE_W-1:0] t_ceil;
    logic [CODE_W-1:0] t;
    logic [CODE_W-1:0] q;
    logic              q_sat;
    logic              t_sat;
    logic              stop;
    logic [15:0]       stamp_w;
    logic [15:0]       ovf_w;
    logic [12:0]       dom;
    int                n;
    q_ceil  = CODE_W'((1 << Q_BITS) - 1);
    t_small = CODE_W'((1 << T_BITS) - 1);
    t_ceil  = CODE_W'((1 << (T_BITS + S_BITS)) - 1);
    stop    = s.last_stamp;
    q_sat   = s.charge_code >= q_ceil;
    q       = q_sat ? q_ceil : s.charge_code;
    t_sat   = first && (s.time_code >= t_ceil);
    n       = 0;
    for (int i = 0; i < 4; i++) begin
      w[i] = '0;
    end
    if (first) begin
      t = t_sat ? t_ceil : s.time_code;
    end else begin
      // later stamps keep only the short time field, excess is lost
      t = (s.time_code > t_small) ? t_small : s.time_code;
    end
    stamp_w = 16'(t & t_small) | 16'(q << T_BITS) | 16'(CODE_W'(s.hlc) << (T_BITS + Q_BITS));
    // stop bit only lands on the last stamp-stream word
    if (stop && !t_sat && !q_sat) begin
      stamp_w[15] = 1'b1;
    end
    w[n] = '{stream_select: STREAM_STAMP, word: stamp_w, last_word: 1'b0};
    n++;
    if (t_sat) begin
      ovf_w = clamp_excess(s.time_code, t_ceil);
      if (stop && !q_sat) begin
        ovf_w[15] = 1'b1;
      end
      w[n] = '{stream_select: STREAM_STAMP, word: ovf_w, last_word: 1'b0};
      n++;
    end
    if (q_sat) begin
      ovf_w = clamp_excess(s.charge_code, q_ceil);
      if (stop) begin
        ovf_w[15] = 1'b1;
      end
      w[n] = '{stream_select: STREAM_STAMP, word: ovf_w, last_word: 1'b0};
      n++;
    end
    if (first) begin
      // dom id: string in the upper bits, (om - 1) mod 64 below
      dom  = {s.string_number, 6'(s.om_number - 7'd1)};
      w[n] = '{stream_select: STREAM_HEADER,
               word: 16'(dom) | 16'(((t >> T_BITS) & CODE_W'((1 << S_BITS) - 1)) << DOM_BITS),
               last_word: 1'b0};
      n++;
    end
    w[n-1].last_word = 1'b1;
    return n;
  endfunction

  function automatic in_item_t mk_stamp(input int str, input int om, input bit hlc,
                                        input bit last, input logic [CODE_W-1:0] t,
                                        input logic [CODE_W-1:0] q);
    in_item_t s;
    s.string_number = 7'(str);
    s.om_number     = 7'(om);
    s.hlc           = hlc;
    s.last_stamp    = last;
    s.time_code     = t;
    s.charge_code   = q;
    return s;
  endfunction

  function automatic out_item_t wd(input logic sel, input logic [15:0] w, input logic lw);
    return '{stream_select: sel, word: w, last_word: lw};
  endfunction

  task automatic add_row(input in_item_t s, input int n, input out_item_t a = '0,
                         input out_item_t b = '0, input out_item_t c = '0,
                         input out_item_t d = '0);
    stim_row_t r;
    r.item     = s;
    r.n_typed  = n;
    r.typed[0] = a;
    r.typed[1] = b;
    r.typed[2] = c;
    r.typed[3] = d;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // time codes spread over the interesting regions around each threshold
  function automatic logic [CODE_W-1:0] pick_time();
    case ($urandom_range(5))
      0: return CODE_W'($urandom_range(255));
      1: return CODE_W'($urandom_range(250, 260));
      2: return CODE_W'($urandom_range(2040, 2056));
      3: return CODE_W'($urandom_range(34810, 34820));
      4: return CODE_W'($urandom_range(2047));
      default: return CODE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_charge();
    case ($urandom_range(4))
      0: return CODE_W'($urandom_range(62));
      1: return CODE_W'($urandom_range(60, 68));
      2: return CODE_W'($urandom_range(32826, 32834));
      default: return CODE_W'($urandom);
    endcase
  endfunction

  // offer one stamp until it transfers, then record the words it must yield
  task automatic send_stamp(input in_item_t s, input int n_typed, input out_item_t typed [4]);
    out_item_t w [4];
    int        n;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= s;
    do begin
      @(posedge clk);
    end while (in_full);
    n = pack_stamp(s, readout_start, w);
    if (n_typed > 0) begin
      n = n_typed;
      w = typed;
    end
    for (int i = 0; i < n; i++) begin
      pending_words.insert(pending_words.size(), w[i]);
    end
    readout_start = s.last_stamp;
    stamps_sent++;
  endtask

  // well-formed readouts of one to four stamps, with some broken last flags
  task automatic run_random(input int n_items);
    out_item_t none [4];
    int        sent;
    int        len;
    int        str;
    bit        last;
    for (int i = 0; i < 4; i++) begin
      none[i] = '0;
    end
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 4);
      str = $urandom_range(127);
      for (int i = 0; i < len; i++) begin
        last = (i == len - 1);
        if ($urandom_range(99) < 12) begin
          last = 1'($urandom_range(1));
        end
        send_stamp(mk_stamp(str, ($urandom_range(9) == 0) ? $urandom_range(127)
                                                          : $urandom_range(1, 64),
                            1'($urandom_range(1)), last, pick_time(), pick_charge()),
                   0, none);
        sent++;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
    err_count++;
  endtask

  // check every word transfer against the oldest pending expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_item);
        err_count++;
      end else begin
        want_word = pending_words.pop_front();
        if (out_item.stream_select !== want_word.stream_select) begin
          report_field("stream_select", 16'(want_word.stream_select),
                       16'(out_item.stream_select));
        end
        if (out_item.word !== want_word.word) begin
          report_field("word", want_word.word, out_item.word);
        end
        if (out_item.last_word !== want_word.last_word) begin
          report_field("last_word", 16'(want_word.last_word), 16'(out_item.last_word));
        end
        words_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // receiver: random pops, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_item       = '0;
    out_pop       = 1'b0;
    readout_start = 1'b1;
    err_count     = 0;
    stamps_sent   = 0;
    words_checked = 0;
    stall_count   = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 47;

    // directed table; the first two rows are readable by hand
    // minimal first stamp with last set: stop on stamp word, zero header
    add_row(mk_stamp(0, 1, 0, 1, 0, 0), 2,
            wd(STREAM_STAMP, 16'h8000, 1'b0), wd(STREAM_HEADER, 16'h0000, 1'b1));
    // everything at its maximum: both codes saturate, excesses clamp
    add_row(mk_stamp(127, 64, 1, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 4,
            wd(STREAM_STAMP, 16'h7FFF, 1'b0), wd(STREAM_STAMP, 16'h7FFF, 1'b0),
            wd(STREAM_STAMP, 16'hFFFF, 1'b0), wd(STREAM_HEADER, 16'hFFFF, 1'b1));
    add_row(mk_stamp(5, 0, 0, 0, 2046, 62), 0);         // om 0 wraps to 63, no saturation
    add_row(mk_stamp(5, 0, 0, 0, 255, 0), 0);           // later stamp, short time at top
    add_row(mk_stamp(5, 0, 1, 0, 256, 63), 0);          // later time clamps, zero charge excess
    add_row(mk_stamp(5, 0, 0, 1, 1000, 64), 0);         // stop moves to charge overflow word
    add_row(mk_stamp(9, 65, 0, 1, 2047, 10), 0);        // time at ceiling, stop on time overflow
    add_row(mk_stamp(9, 127, 1, 0, 34814, 62), 0);      // time excess exactly at 15-bit max
    add_row(mk_stamp(9, 64, 0, 1, 31'h7FFF_FFFF, 32830), 0);
    add_row(mk_stamp(100, 33, 1, 0, 34815, 32831), 0);  // both excesses one past the clamp
    add_row(mk_stamp(100, 33, 0, 0, 0, 31'h7FFF_FFFF), 0);
    add_row(mk_stamp(100, 33, 1, 1, 31'h7FFF_FFFF, 0), 0);
    add_row(mk_stamp(127, 1, 0, 0, 2048, 63), 0);       // time excess one, charge excess zero
    add_row(mk_stamp(0, 2, 1, 1, 1, 1), 0);
    add_row(mk_stamp(64, 10, 0, 0, 0, 0), 0);
    add_row(mk_stamp(1, 10, 1, 1, 255, 62), 0);
    add_row(mk_stamp(85, 42, 0, 1, 31'h2AAA_AAAA, 31'h5555_5555), 0);
    add_row(mk_stamp(42, 21, 1, 0, 31'h5555_5555, 31'h2AAA_AAAA), 0);
    add_row(mk_stamp(42, 21, 0, 1, 31'h5555_5555, 31'h2AAA_AAAA), 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase one: receiver idles more than sender
    foreach (dir_rows[i]) begin
      send_stamp(dir_rows[i].item, dir_rows[i].n_typed, dir_rows[i].typed);
    end
    run_random(ITEMS_PER_PHASE);

    // phase two: roles swapped
    send_idle_pct = 47;
    recv_idle_pct = 22;
    run_random(ITEMS_PER_PHASE);

    // phase three: no idling, with one long receiver hold-off to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(ITEMS_PER_PHASE);

    @(negedge clk);
    in_push <= 1'b0;

    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("covered %0d stamps (directed table and random readouts) over three idle mixes",
             stamps_sent);
    $display("checked %0d words including a long output hold-off", words_checked);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psw_pkg.sv
rtl/psw_front.sv
rtl/psw_queue.sv
rtl/psw_back.sv
rtl/pulse_stamp_word_packer.sv
bench/tb_pulse_stamp_word_packer.sv
